FILE: design/farthest_seat_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the farthest seat allocator
// Implication checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FARTHEST_SEAT_ALLOCATOR_CORE_DEFINES_SVH
`define FARTHEST_SEAT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define FSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared widths, codes and types of the farthest seat allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

	localparam int MAX_SEATS = 1024;
	localparam int IDX_W     = $clog2(MAX_SEATS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int CFG_W     = 11;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CFG_W-1:0] cfg_t;

	localparam cfg_t NUM_SEATS_RST = cfg_t'(1024);

	localparam logic [ADDR_W-3:0] REG_NUM_SEATS = '0;

	localparam logic CMD_SEAT  = 1'b0;
	localparam logic CMD_LEAVE = 1'b1;

endpackage

FILE: design/fsa_req_if.sv
// ----------------------------------------------------------------------------
// fsa_req_if
// Request channel: a seat or leave command with its slot index.
// ----------------------------------------------------------------------------
interface fsa_req_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	fsa_pkg::idx_t      seat_index;

	modport source (output valid, cmd, seat_index, input ready);
	modport sink   (input valid, cmd, seat_index, output ready);
endinterface

FILE: design/fsa_res_if.sv
// ----------------------------------------------------------------------------
// fsa_res_if
// Result channel: assigned slot and row-full flag.
// ----------------------------------------------------------------------------
interface fsa_res_if;
	logic               valid;
	logic               ready;
	fsa_pkg::idx_t      seat;
	logic               full_res;

	modport source (output valid, seat, full_res, input ready);
	modport sink   (input valid, seat, full_res, output ready);
endinterface

FILE: design/farthest_seat_allocator_core.sv
// ----------------------------------------------------------------------------
// farthest_seat_allocator_core
// Row of occupancy bits; seats go to the slot farthest from any neighbor.
// ----------------------------------------------------------------------------
// The occupancy bits live in a single-bit RAM of MAX_SEATS entries. After
// reset a clearing pass writes every entry, during which no request is
// taken (register writes still are). A leave request clears its slot as it
// is accepted. A seat request scans the active slots through the RAM read
// port at one slot per cycle, then passes the final and emit states into the
// result register; a new request is taken while that result waits.
// ----------------------------------------------------------------------------
`include "farthest_seat_allocator_core_defines.svh"

module farthest_seat_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fsa_pkg::ADDR_W-1:0]    paddr,
	input  logic [fsa_pkg::DATA_W-1:0]    pwdata,
	output logic [fsa_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	fsa_req_if.sink                       req,
	fsa_res_if.source                     res
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINAL,
		ST_EMIT
	} state_t;

	state_t          state_q;
	fsa_pkg::cfg_t   num_seats_q;
	fsa_pkg::cnt_t   n_eff;
	fsa_pkg::idx_t   clr_q;
	fsa_pkg::idx_t   last_scan_q;
	fsa_pkg::idx_t   rd_addr_q;
	logic            issue_done_q;
	logic            valid_s1;
	fsa_pkg::idx_t   idx_s1;
	logic            seen_q;
	fsa_pkg::idx_t   last_q;
	logic            found_q;
	fsa_pkg::idx_t   best_i_q;
	fsa_pkg::idx_t   best_d_q;
	logic            full_q;
	logic            out_valid_q;
	fsa_pkg::idx_t   out_seat_q;
	logic            out_full_q;

	logic            cfg_wr;
	logic            req_acc;
	logic            leave_ok;
	logic            out_load;
	logic            ram_we;
	fsa_pkg::idx_t   ram_waddr;
	logic            ram_wdata;
	logic            ram_re;
	logic            ram_rdata;
	fsa_pkg::idx_t   diff;
	fsa_pkg::idx_t   cand_i;
	fsa_pkg::idx_t   cand_d;
	logic            cand_take;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
	                (paddr[fsa_pkg::ADDR_W-1:2] == fsa_pkg::REG_NUM_SEATS);

	always_comb begin
		if (paddr[fsa_pkg::ADDR_W-1:2] == fsa_pkg::REG_NUM_SEATS) begin
			prdata = fsa_pkg::DATA_W'(num_seats_q);
		end else begin
			prdata = '0;
		end
	end

	always_comb begin
		if (num_seats_q == '0) begin
			n_eff = fsa_pkg::cnt_t'(1);
		end else if (32'(num_seats_q) > fsa_pkg::MAX_SEATS) begin
			n_eff = fsa_pkg::cnt_t'(fsa_pkg::MAX_SEATS);
		end else begin
			n_eff = fsa_pkg::cnt_t'(num_seats_q);
		end
	end

	// handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign leave_ok  = (fsa_pkg::cnt_t'(req.seat_index) < n_eff);
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || res.ready);

	assign res.valid    = out_valid_q;
	assign res.seat     = out_seat_q;
	assign res.full_res = out_full_q;

	// candidate from the gap that ends at the current occupied slot
	always_comb begin
		if (state_q == ST_FINAL) begin
			diff = last_scan_q - last_q;
		end else begin
			diff = idx_s1 - last_q;
		end
		cand_take = 1'b0;
		cand_i    = '0;
		cand_d    = '0;
		if (state_q == ST_FINAL) begin
			cand_i = last_scan_q;
			cand_d = diff;
		end else if (seen_q) begin
			cand_i = last_q + (diff >> 1);
			cand_d = diff >> 1;
		end else begin
			cand_i = '0;
			cand_d = idx_s1;
		end
		if (cand_d != '0 && (!found_q || cand_d > best_d_q)) begin
			cand_take = (state_q == ST_FINAL) ? seen_q : (valid_s1 && ram_rdata);
		end
	end

	// RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				ram_we    = req_acc && (req.cmd == fsa_pkg::CMD_LEAVE) && leave_ok;
				ram_waddr = req.seat_index;
			end
			ST_EMIT: begin
				ram_we    = out_load && !full_q;
				ram_waddr = best_i_q;
				ram_wdata = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_re = (state_q == ST_SCAN) && !issue_done_q;

	fsa_ram #(
		.WIDTH (1),
		.DEPTH (fsa_pkg::MAX_SEATS)
	) u_occ_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			num_seats_q  <= fsa_pkg::NUM_SEATS_RST;
			clr_q        <= '0;
			last_scan_q  <= '0;
			rd_addr_q    <= '0;
			issue_done_q <= 1'b0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			seen_q       <= 1'b0;
			last_q       <= '0;
			found_q      <= 1'b0;
			best_i_q     <= '0;
			best_d_q     <= '0;
			full_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_seat_q   <= '0;
			out_full_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				num_seats_q <= pwdata[fsa_pkg::CFG_W-1:0];
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_seat_q  <= full_q ? '0 : best_i_q;
				out_full_q  <= full_q;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			valid_s1 <= ram_re;
			if (ram_re) begin
				idx_s1 <= rd_addr_q;
			end

			if (cand_take) begin
				found_q  <= 1'b1;
				best_i_q <= cand_i;
				best_d_q <= cand_d;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == fsa_pkg::idx_t'(fsa_pkg::MAX_SEATS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc && req.cmd == fsa_pkg::CMD_SEAT) begin
						state_q      <= ST_SCAN;
						last_scan_q  <= fsa_pkg::idx_t'(n_eff - 1'b1);
						rd_addr_q    <= '0;
						issue_done_q <= 1'b0;
						seen_q       <= 1'b0;
						last_q       <= '0;
						found_q      <= 1'b0;
						best_i_q     <= '0;
						best_d_q     <= '0;
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						if (rd_addr_q == last_scan_q) begin
							issue_done_q <= 1'b1;
						end else begin
							rd_addr_q <= rd_addr_q + 1'b1;
						end
					end
					if (valid_s1 && ram_rdata) begin
						seen_q <= 1'b1;
						last_q <= idx_s1;
					end
					if (valid_s1 && idx_s1 == last_scan_q) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					// empty row: slot 0; nothing free: full
					if (!seen_q) begin
						found_q  <= 1'b1;
						best_i_q <= '0;
					end
					full_q  <= seen_q && !found_q && !cand_take;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FSA_ASSERT_IMP(a_scan_in_range, valid_s1, idx_s1 <= last_scan_q, "scan past last slot")
	`FSA_ASSERT_IMP(a_no_write_in_scan, state_q == ST_SCAN, !ram_we, "RAM write during scan")
	`FSA_ASSERT_IMP(a_full_seat_zero, res.valid && res.full_res, res.seat == '0, "full with seat")
	`FSA_ASSERT_NXT(a_seat_starts_scan, req_acc && req.cmd == fsa_pkg::CMD_SEAT, state_q == ST_SCAN, "seat request did not start scan")

endmodule

FILE: design/fsa_ram.sv
// ----------------------------------------------------------------------------
// fsa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fsa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
